// ----- hw/rtl/lic_pkg.sv -----
// ----------------------------------------------------------------------------
// lic_pkg
// Shared types and constants of the level interrupt controller.
// ----------------------------------------------------------------------------
package lic_pkg;

  // Default number of register groups (eight sources each)
  localparam int NUM_GROUPS_DEF = 16;

  // Vector address limits and special vectors
  localparam logic [6:0] VEC_MIN      = 7'd6;
  localparam logic [6:0] VEC_LEVEL3   = 7'd6;
  localparam logic [6:0] VEC_LEVEL2   = 7'd8;
  localparam logic [7:0] BRK_VECTOR   = 8'h04;
  localparam logic [1:0] HW_EXTRA_CYC = 2'd3;

  // Exception levels
  localparam logic [1:0] LEVEL_1 = 2'd1;
  localparam logic [1:0] LEVEL_2 = 2'd2;
  localparam logic [1:0] LEVEL_3 = 2'd3;

  typedef enum logic [2:0] {
    OP_WR_EN   = 3'd0,
    OP_WR_REQ  = 3'd1,
    OP_RD_EN   = 3'd2,
    OP_RD_REQ  = 3'd3,
    OP_SWI     = 3'd4,
    OP_BRK     = 3'd5,
    OP_DEFINE  = 3'd6,
    OP_RELEASE = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_BAD_BIT     = 2'd1,
    ST_BAD_VECTOR  = 2'd2,
    ST_ALREADY_DEF = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_SCAN,
    S_STORE,
    S_FINISH
  } state_t;

  // One memory row holds everything of one group
  typedef struct packed {
    logic [7:0]      pend;
    logic [7:0]      en;
    logic [7:0][6:0] vec;
  } row_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       taken;
    logic [1:0] new_level;
    logic [7:0] vector_address;
    logic       clear_master_enable;
    logic [1:0] extra_cycles;
    logic       wake;
    logic [1:0] status;
  } result_t;

endpackage

// ----- hw/rtl/level_interrupt_controller_core.sv -----
// States: reads, swi, brk, release, out-of-range groups and bad-bit defines pass through
//   LOAD, FINISH; other defines LOAD, STORE, FINISH; en/req writes LOAD, SCAN, STORE, FINISH.
// One request at a time, taken only in IDLE once the last result is passed on; write enable or
//   request is set by the eight-step source scan through the single shared vector compare.
// Reset (rst, synchronous): clears the sequencer, output valid, acceptance mask and the
//   per-group row valid bits; an unwritten group reads as all zero. No clearing pass.
// ----------------------------------------------------------------------------
// level_interrupt_controller_core
// Priority interrupt controller: per-group enable/request bytes, vector table,
// sequential source scan with a shared acceptance unit.
// ----------------------------------------------------------------------------
module level_interrupt_controller_core #(
  parameter int NUM_GROUPS = lic_pkg::NUM_GROUPS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  operation,
  input  logic [5:0]  group_index,
  input  logic [3:0]  bit_index,
  input  logic [7:0]  data_byte,
  input  logic [15:0] vector_in,
  input  logic [1:0]  cpu_level,
  input  logic        cpu_master_enable,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  read_data,
  output logic        taken,
  output logic [1:0]  new_level,
  output logic [7:0]  vector_address,
  output logic        clear_master_enable,
  output logic [1:0]  extra_cycles,
  output logic        wake,
  output logic [1:0]  status
);

  localparam int GW = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;

  lic_pkg::state_t state, state_next;

  // Group memory and row valid bits
  lic_pkg::row_t         mem [NUM_GROUPS];
  lic_pkg::row_t         rd_q;
  logic                  rvalid_q;
  logic [NUM_GROUPS-1:0] row_valid;

  // Request registers
  lic_pkg::op_t op_q;
  logic [5:0]   g_q;
  logic [3:0]   bit_q;
  logic [7:0]   data_q;
  logic [15:0]  vin_q;
  logic [1:0]   lvl_q;
  logic         mie_q;
  logic         ok_q;

  // Working row and scan counter
  logic [7:0]      en_q;
  logic [7:0]      pend_q;
  logic [7:0][6:0] vec_q;
  logic [2:0]      cnt;
  logic            mask;

  lic_pkg::result_t res_q, out_q;

  logic             accept;
  logic             ok_in;
  logic             load_row;
  logic             scan_step;
  logic             mem_we;
  logic             finish;
  lic_pkg::row_t    row_eff;
  lic_pkg::row_t    row_wr;
  logic [GW-1:0]    wr_addr;

  // Shared acceptance unit signals
  logic [6:0] sv;
  logic       sv_ok;
  logic       s_raise;
  logic       s_en;
  logic       s_cond;
  logic [1:0] s_lvl;

  assign accept  = in_valid && in_ready;
  assign ok_in   = {1'b0, group_index} < 7'(NUM_GROUPS);
  assign row_eff = rvalid_q ? rd_q : '0;
  assign wr_addr = g_q[GW-1:0];

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      lic_pkg::S_IDLE: begin
        if (accept) state_next = lic_pkg::S_LOAD;
      end
      lic_pkg::S_LOAD: begin
        if (ok_q && (op_q == lic_pkg::OP_WR_EN || op_q == lic_pkg::OP_WR_REQ)) begin
          state_next = lic_pkg::S_SCAN;
        end else if (op_q == lic_pkg::OP_DEFINE && ok_q && !bit_q[3]) begin
          state_next = lic_pkg::S_STORE;
        end else begin
          state_next = lic_pkg::S_FINISH;
        end
      end
      lic_pkg::S_SCAN: begin
        if (cnt == 3'd7) state_next = lic_pkg::S_STORE;
      end
      lic_pkg::S_STORE: state_next = lic_pkg::S_FINISH;
      lic_pkg::S_FINISH: begin
        if (!out_valid || out_ready) state_next = lic_pkg::S_IDLE;
      end
      default: state_next = lic_pkg::S_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready  = 1'b0;
    load_row  = 1'b0;
    scan_step = 1'b0;
    mem_we    = 1'b0;
    finish    = 1'b0;
    case (state)
      lic_pkg::S_IDLE:   in_ready  = 1'b1;
      lic_pkg::S_LOAD:   load_row  = 1'b1;
      lic_pkg::S_SCAN:   scan_step = 1'b1;
      lic_pkg::S_STORE:  mem_we    = 1'b1;
      lic_pkg::S_FINISH: finish    = !out_valid || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= lic_pkg::S_IDLE;
    else     state <= state_next;
  end

  // Group memory: row read on request, row write-back in store
  always_ff @(posedge clk) begin
    if (accept) rd_q <= mem[group_index[GW-1:0]];
    if (mem_we) mem[wr_addr] <= row_wr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      rvalid_q  <= 1'b0;
    end else begin
      if (accept) rvalid_q <= row_valid[group_index[GW-1:0]];
      if (mem_we) row_valid[wr_addr] <= 1'b1;
    end
  end

  assign row_wr.pend = pend_q;
  assign row_wr.en   = en_q;
  assign row_wr.vec  = vec_q;

  // Shared acceptance unit: one source per scan step
  always_comb begin
    sv      = vec_q[cnt];
    sv_ok   = sv >= lic_pkg::VEC_MIN;
    s_raise = data_q[cnt] && sv_ok;
    s_en    = en_q[cnt];
    s_cond  = s_en && !mask;
    if (sv == lic_pkg::VEC_LEVEL3) begin
      s_lvl = lic_pkg::LEVEL_3;
    end else if (sv == lic_pkg::VEC_LEVEL2) begin
      s_cond = s_cond && (lvl_q <= 2'd2);
      s_lvl  = lic_pkg::LEVEL_2;
    end else begin
      s_cond = s_cond && mie_q && (lvl_q <= 2'd1);
      s_lvl  = lic_pkg::LEVEL_1;
    end
  end

  // Request capture
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q   <= lic_pkg::op_t'(operation);
      g_q    <= group_index;
      bit_q  <= bit_index;
      data_q <= data_byte;
      vin_q  <= vector_in;
      lvl_q  <= cpu_level;
      mie_q  <= cpu_master_enable;
      ok_q   <= ok_in;
    end
  end

  // Operation datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= 1'b0;
      cnt  <= '0;
    end else if (load_row) begin
      cnt   <= '0;
      en_q  <= row_eff.en;
      pend_q <= row_eff.pend;
      vec_q <= row_eff.vec;
      res_q <= '0;
      case (op_q)
        lic_pkg::OP_WR_EN: en_q <= '0;
        lic_pkg::OP_WR_REQ: pend_q <= data_q;
        lic_pkg::OP_RD_EN: begin
          if (ok_q) res_q.read_data <= row_eff.en;
        end
        lic_pkg::OP_RD_REQ: begin
          if (ok_q) res_q.read_data <= row_eff.pend;
        end
        lic_pkg::OP_SWI: begin
          mask                      <= 1'b1;
          res_q.taken               <= 1'b1;
          res_q.new_level           <= lic_pkg::LEVEL_1;
          res_q.vector_address      <= {1'b1, g_q, 1'b0};
          res_q.clear_master_enable <= 1'b1;
        end
        lic_pkg::OP_BRK: begin
          mask                 <= 1'b1;
          res_q.taken          <= 1'b1;
          res_q.new_level      <= lic_pkg::LEVEL_2;
          res_q.vector_address <= lic_pkg::BRK_VECTOR;
        end
        lic_pkg::OP_DEFINE: begin
          if (!ok_q || bit_q[3]) begin
            res_q.status <= lic_pkg::ST_BAD_BIT;
          end else if (vin_q[15:7] != '0 || {vin_q[6:1], 1'b0} < lic_pkg::VEC_MIN) begin
            res_q.status <= lic_pkg::ST_BAD_VECTOR;
          end else if (row_eff.vec[bit_q[2:0]] != '0) begin
            res_q.status <= lic_pkg::ST_ALREADY_DEF;
          end else begin
            res_q.status          <= lic_pkg::ST_OK;
            vec_q[bit_q[2:0]]     <= {vin_q[6:1], 1'b0};
          end
        end
        lic_pkg::OP_RELEASE: mask <= 1'b0;
        default: ;
      endcase
    end else if (scan_step) begin
      cnt <= cnt + 3'd1;
      if (op_q == lic_pkg::OP_WR_EN) begin
        if (s_raise) en_q[cnt] <= 1'b1;
      end else if (s_raise) begin
        if (s_cond) begin
          mask                      <= 1'b1;
          res_q.taken               <= 1'b1;
          res_q.new_level           <= s_lvl;
          res_q.vector_address      <= {1'b0, sv};
          res_q.clear_master_enable <= (s_lvl == lic_pkg::LEVEL_1);
          res_q.extra_cycles        <= lic_pkg::HW_EXTRA_CYC;
          pend_q[cnt]               <= 1'b0;
        end else begin
          pend_q[cnt] <= 1'b1;
        end
        if (s_en) res_q.wake <= 1'b1;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) out_q <= res_q;
  end

  assign read_data           = out_q.read_data;
  assign taken               = out_q.taken;
  assign new_level           = out_q.new_level;
  assign vector_address      = out_q.vector_address;
  assign clear_master_enable = out_q.clear_master_enable;
  assign extra_cycles        = out_q.extra_cycles;
  assign wake                = out_q.wake;
  assign status              = out_q.status;

endmodule
